>>> sv/kwm_pkg.sv
// Shared types and codes for the k-way sorted merge block.
`timescale 1ns / 1ps
`default_nettype none
package kwm_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_PULL   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_POP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;
    logic clear;
    logic nop;
    logic pull_start;
    logic scan;
    logic pop;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage
`default_nettype wire

>>> sv/kwm_ctrl.sv
// Controller state machine for the k-way sorted merge block.
`timescale 1ns / 1ps
`default_nettype none
module kwm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    mode,
  input  wire kwm_pkg::stat_t stat,
  output kwm_pkg::cmd_t      cmd,
  output logic               busy
);
  import kwm_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode_t'(mode) == MODE_PULL)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_POP;
      end
      ST_POP: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_t'(mode))
            MODE_APPEND: cmd.append     = 1'b1;
            MODE_PULL:   cmd.pull_start = 1'b1;
            MODE_CLEAR:  cmd.clear      = 1'b1;
            MODE_NONE:   cmd.nop        = 1'b1;
          endcase
        end
      end
      ST_SCAN:  cmd.scan = 1'b1;
      ST_DRAIN: ;
      ST_POP:   cmd.pop  = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/kwm_datapath.sv
// Datapath of the k-way sorted merge: element store, list pointers, head scan, result.
`timescale 1ns / 1ps
`default_nettype none
module kwm_datapath #(
  parameter int NUM_LISTS   = 8,
  parameter int LIST_DEPTH  = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire kwm_pkg::cmd_t cmd,
  input  wire logic [2:0]    list_index,
  input  wire logic signed [15:0] value,
  output kwm_pkg::stat_t     stat,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [15:0] merged_value,
  output logic [2:0]         source_list
);
  import kwm_pkg::*;

  localparam int LW        = $clog2(NUM_LISTS);
  localparam int PTR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata;

  logic [PTR_W-1:0] rp [NUM_LISTS];
  logic [CNT_W-1:0] fc [NUM_LISTS];

  logic [LW-1:0]          scan_idx;
  logic                   rd_pend;
  logic [LW-1:0]          rd_list;
  logic                   best_found;
  logic [LW-1:0]          best_idx;
  logic [VALUE_WIDTH-1:0] best_val;

  logic [LW-1:0]          sel;
  logic [PTR_W-1:0]       rp_sel;
  logic [CNT_W-1:0]       fc_sel;
  logic [PTR_W-1:0]       rp_inc;
  logic [SUM_W-1:0]       tail_sum;
  logic [PTR_W-1:0]       slot;
  logic [AW-1:0]          addr;
  logic                   in_range;
  logic                   list_full;
  logic                   app_ok;
  logic                   mem_re;
  logic [VALUE_WIDTH-1:0] wval;
  logic                   take;

  assign in_range = (7'(list_index) < 7'(NUM_LISTS));

  always_comb begin
    if (cmd.pop) begin
      sel = best_idx;
    end else if (cmd.scan) begin
      sel = scan_idx;
    end else begin
      sel = LW'(list_index);
    end
  end

  assign rp_sel    = rp[sel];
  assign fc_sel    = fc[sel];
  assign list_full = !in_range || (fc_sel >= CNT_W'(LIST_DEPTH));
  assign app_ok    = cmd.append && !list_full;
  assign rp_inc    = (rp_sel == PTR_W'(LIST_DEPTH - 1)) ? '0 : rp_sel + PTR_W'(1);

  // Tail slot wraps once at most since the read position stays below the depth and the fill count does not exceed it.
  assign tail_sum = SUM_W'(rp_sel) + SUM_W'(fc_sel);
  always_comb begin
    if (tail_sum >= SUM_W'(LIST_DEPTH)) begin
      slot = PTR_W'(tail_sum - SUM_W'(LIST_DEPTH));
    end else begin
      slot = PTR_W'(tail_sum);
    end
  end

  assign addr   = AW'(AW'(sel) * LIST_DEPTH) + AW'(cmd.append ? slot : rp_sel);
  assign mem_re = cmd.scan && (fc_sel != '0);
  assign wval   = VALUE_WIDTH'(value);

  always_ff @(posedge clk) begin
    if (app_ok) begin
      mem[addr] <= wval;
    end
    if (mem_re) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        rp[i] <= '0;
        fc[i] <= '0;
      end
    end else if (app_ok) begin
      fc[sel] <= fc_sel + CNT_W'(1);
    end else if (cmd.pop && best_found) begin
      rp[sel] <= rp_inc;
      fc[sel] <= fc_sel - CNT_W'(1);
    end
  end

  assign stat.scan_last = (scan_idx == LW'(NUM_LISTS - 1));

  // A strict compare while scanning upward keeps ties on the lowest list.
  assign take = rd_pend && (!best_found || ($signed(rdata) < $signed(best_val)));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend    <= 1'b0;
      best_found <= 1'b0;
      scan_idx   <= '0;
    end else begin
      rd_pend <= mem_re;
      if (cmd.pull_start) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_idx <= scan_idx + LW'(1);
        end
        if (take) begin
          best_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_list <= scan_idx;
    end
    if (take) begin
      best_idx <= rd_list;
      best_val <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.append || cmd.clear || cmd.nop || cmd.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append || cmd.clear || cmd.nop || cmd.pop) begin
      if (cmd.pop && best_found) begin
        status       <= STATUS_OK;
        merged_value <= 16'(best_val);
        source_list  <= 3'(best_idx);
      end else begin
        merged_value <= '0;
        source_list  <= '0;
        if (cmd.append && list_full) begin
          status <= STATUS_FULL;
        end else if (cmd.pop) begin
          status <= STATUS_EMPTY;
        end else begin
          status <= STATUS_OK;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/k_way_sorted_merge.sv
// Append, pull, clear: one FIFO per list in a shared store; pull yields the smallest head.
// Append, clear and the unused mode: result strobe in the cycle after the request, and the
// next request can follow in that same cycle.
// Pull: busy through the scan, drain and pop states, with the result strobe after the pop; the
// heads are scanned one list per cycle through the single read port of the element store.
// rst clears the fill counts, read positions and controller; the element store keeps its data.
`timescale 1ns / 1ps
`default_nettype none
module k_way_sorted_merge #(
  parameter int NUM_LISTS   = 8,
  parameter int LIST_DEPTH  = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         mode,
  input  wire logic [2:0]         list_index,
  input  wire logic signed [15:0] value,
  output logic                    busy,
  output logic                    done,
  output logic [1:0]              status,
  output logic signed [15:0]      merged_value,
  output logic [2:0]              source_list
);
  import kwm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  kwm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  kwm_datapath #(
    .NUM_LISTS   (NUM_LISTS),
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .list_index   (list_index),
    .value        (value),
    .stat         (stat),
    .done         (done),
    .status       (status),
    .merged_value (merged_value),
    .source_list  (source_list)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a pull is still in progress");

  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_PULL)) |=> busy)
    else $error("pull request did not start a head scan");

  a_short_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode != MODE_PULL)) |=> done)
    else $error("non-pull request gave no result in the next cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STATUS_OK)) |-> ((merged_value == 16'sd0) && (source_list == 3'd0)))
    else $error("failed request returned a nonzero value or source");

endmodule
`default_nettype wire
